// ===== hdl/r1u_pkg.sv =====
package r1u_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MAX_ROWS  = 256;
  localparam int unsigned MAX_COLS  = 256;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ROW_AW    = $clog2(MAX_ROWS);
  localparam int unsigned COL_AW    = $clog2(MAX_COLS);
  localparam int unsigned PROD_W    = 2 * DATA_W;
  localparam int unsigned SHIFT_W   = PROD_W - FRAC_BITS;
  localparam int unsigned SUM_W     = SHIFT_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic signed [DATA_W-1:0] SAT_HI = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_LO = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0]  SUM_HI = SUM_W'(SAT_HI);
  localparam logic signed [SUM_W-1:0]  SUM_LO = SUM_W'(SAT_LO);

  localparam logic signed [DATA_W-1:0] ALPHA_RESET = DATA_W'(65536);
  localparam logic [CNT_W-1:0]         ROWS_RESET  = CNT_W'(256);
  localparam logic [CNT_W-1:0]         COLS_RESET  = CNT_W'(256);

  typedef enum logic [1:0] {
    OP_LOAD_X = 2'd0,
    OP_LOAD_Y = 2'd1,
    OP_UPDATE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA = 2'd0,
    CFG_ROWS  = 2'd1,
    CFG_COLS  = 2'd2
  } cfg_e;

  typedef struct packed {
    logic [1:0]               operation;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic signed [DATA_W-1:0] data_value;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] updated_value;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic [1:0]               status;
  } out_word_t;

  function automatic logic sat_hit(input logic signed [SUM_W-1:0] v);
    return (v > SUM_HI) || (v < SUM_LO);
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_clip(input logic signed [SUM_W-1:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > SUM_HI) begin
      r = SAT_HI;
    end else if (v < SUM_LO) begin
      r = SAT_LO;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/r1u_ram.sv =====
module r1u_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rank_one_matrix_update_top.sv =====
// Rank-one update engine: A = A + alpha * x * y^T, one matrix element per word.
// Input channel (in_valid_i / in_ready_o / in_data_i) carries load-x, load-y and
// update words; only updates produce an output word on out_valid_o / out_ready_i.
// Load x words first, set alpha, then load y words (they store alpha * y), then
// stream update words. A load is visible to every word accepted after it.
// An accepted update word moves from stage a through the store read (stage c), the
// x * y multiply (stage d), and the add and saturate into the output register.
// Throughput: one word per cycle; the four stages advance together whenever the
// output register is empty or being taken, so in_ready_o = !out_valid_o | out_ready_i.
// When the receiver stalls, the whole pipe holds and nothing is lost or repeated.
// The user writes configuration (cfg_we_i, cfg_idx_i, cfg_data_i) only while the
// block is idle (not enforced): 0 alpha (Q16.16), 1 rows in use, 2 columns in use.
// Reset empties the pipe and restores alpha = 1.0 and 256 rows and columns; the x
// and y stores are not cleared and must be loaded before they are used.
module rank_one_matrix_update_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [r1u_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [r1u_pkg::DATA_W-1:0]          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  r1u_pkg::in_word_t                   in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output r1u_pkg::out_word_t                  out_data_o
);

  // configuration
  logic signed [r1u_pkg::DATA_W-1:0] alpha_q;
  logic [r1u_pkg::CNT_W-1:0]         rows_q;
  logic [r1u_pkg::CNT_W-1:0]         cols_q;

  logic advance;

  // stage a: accepted word and alpha * data
  logic                               a_valid_q;
  logic [1:0]                         a_op_q;
  logic [r1u_pkg::IDX_W-1:0]          a_row_q;
  logic [r1u_pkg::IDX_W-1:0]          a_col_q;
  logic signed [r1u_pkg::DATA_W-1:0]  a_val_q;
  logic signed [r1u_pkg::PROD_W-1:0]  a_yprod_q;
  logic signed [r1u_pkg::PROD_W-1:0]  a_yprod_d;

  // stage c: store read data
  logic                               c_valid_q;
  logic                               c_oor_q;
  logic                               c_oor_d;
  logic [r1u_pkg::IDX_W-1:0]          c_row_q;
  logic [r1u_pkg::IDX_W-1:0]          c_col_q;
  logic signed [r1u_pkg::DATA_W-1:0]  c_val_q;
  logic [r1u_pkg::DATA_W-1:0]         x_rdata;
  logic [r1u_pkg::DATA_W-1:0]         y_rdata;

  // stage d: x * scaled y
  logic                               d_valid_q;
  logic                               d_oor_q;
  logic [r1u_pkg::IDX_W-1:0]          d_row_q;
  logic [r1u_pkg::IDX_W-1:0]          d_col_q;
  logic signed [r1u_pkg::DATA_W-1:0]  d_val_q;
  logic signed [r1u_pkg::PROD_W-1:0]  d_prod_q;
  logic signed [r1u_pkg::PROD_W-1:0]  d_prod_d;

  // output register
  logic                               out_valid_q;
  r1u_pkg::out_word_t                 out_data_q;
  r1u_pkg::out_word_t                 out_data_d;

  // store ports
  logic                               x_we;
  logic                               y_we;
  logic                               rd_en;
  logic signed [r1u_pkg::SUM_W-1:0]   yshift;
  logic signed [r1u_pkg::DATA_W-1:0]  yscaled;
  logic signed [r1u_pkg::SUM_W-1:0]   sum;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= r1u_pkg::ALPHA_RESET;
      rows_q  <= r1u_pkg::ROWS_RESET;
      cols_q  <= r1u_pkg::COLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        r1u_pkg::CFG_ALPHA: alpha_q <= cfg_data_i;
        r1u_pkg::CFG_ROWS:  rows_q  <= cfg_data_i[r1u_pkg::CNT_W-1:0];
        r1u_pkg::CFG_COLS:  cols_q  <= cfg_data_i[r1u_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage a
  assign a_yprod_d = r1u_pkg::PROD_W'(alpha_q) * r1u_pkg::PROD_W'(in_data_i.data_value);

  // ---------------------------------------------------------------- stores
  // shift right by 16 keeps the sign: take the upper bits of the product
  assign yshift  = r1u_pkg::SUM_W'($signed(a_yprod_q[r1u_pkg::PROD_W-1:r1u_pkg::FRAC_BITS]));
  assign yscaled = r1u_pkg::sat_clip(yshift);

  assign x_we  = advance && a_valid_q && (a_op_q == r1u_pkg::OP_LOAD_X)
                 && (32'(a_row_q) < r1u_pkg::MAX_ROWS);
  assign y_we  = advance && a_valid_q && (a_op_q == r1u_pkg::OP_LOAD_Y)
                 && (32'(a_col_q) < r1u_pkg::MAX_COLS);
  assign rd_en = advance && a_valid_q && (a_op_q == r1u_pkg::OP_UPDATE);

  r1u_ram #(
    .WIDTH(r1u_pkg::DATA_W),
    .DEPTH(r1u_pkg::MAX_ROWS)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (r1u_pkg::ROW_AW'(a_row_q)),
    .wdata_i (a_val_q),
    .re_i    (rd_en),
    .raddr_i (r1u_pkg::ROW_AW'(a_row_q)),
    .rdata_o (x_rdata)
  );

  r1u_ram #(
    .WIDTH(r1u_pkg::DATA_W),
    .DEPTH(r1u_pkg::MAX_COLS)
  ) u_y_ram (
    .clk_i   (clk_i),
    .we_i    (y_we),
    .waddr_i (r1u_pkg::COL_AW'(a_col_q)),
    .wdata_i (yscaled),
    .re_i    (rd_en),
    .raddr_i (r1u_pkg::COL_AW'(a_col_q)),
    .rdata_o (y_rdata)
  );

  assign c_oor_d = (r1u_pkg::CNT_W'(a_row_q) >= rows_q) || (32'(a_row_q) >= r1u_pkg::MAX_ROWS)
                || (r1u_pkg::CNT_W'(a_col_q) >= cols_q) || (32'(a_col_q) >= r1u_pkg::MAX_COLS);

  // ---------------------------------------------------------------- stage d
  assign d_prod_d = r1u_pkg::PROD_W'($signed(x_rdata)) * r1u_pkg::PROD_W'($signed(y_rdata));

  // ---------------------------------------------------------------- output
  assign sum = r1u_pkg::SUM_W'(d_val_q)
             + r1u_pkg::SUM_W'($signed(d_prod_q[r1u_pkg::PROD_W-1:r1u_pkg::FRAC_BITS]));

  always_comb begin
    out_data_d.out_row = d_row_q;
    out_data_d.out_col = d_col_q;
    if (d_oor_q) begin
      out_data_d.updated_value = d_val_q;
      out_data_d.status        = r1u_pkg::ST_RANGE;
    end else begin
      out_data_d.updated_value = r1u_pkg::sat_clip(sum);
      out_data_d.status        = r1u_pkg::sat_hit(sum) ? r1u_pkg::ST_SAT : r1u_pkg::ST_OK;
    end
  end

  // valid bits; loads drop out after the store write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      c_valid_q   <= 1'b0;
      d_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      a_valid_q   <= in_valid_i;
      c_valid_q   <= rd_en;
      d_valid_q   <= c_valid_q;
      out_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      a_op_q     <= in_data_i.operation;
      a_row_q    <= in_data_i.row_index;
      a_col_q    <= in_data_i.col_index;
      a_val_q    <= in_data_i.data_value;
      a_yprod_q  <= a_yprod_d;
      c_oor_q    <= c_oor_d;
      c_row_q    <= a_row_q;
      c_col_q    <= a_col_q;
      c_val_q    <= a_val_q;
      d_oor_q    <= c_oor_q;
      d_row_q    <= c_row_q;
      d_col_q    <= c_col_q;
      d_val_q    <= c_val_q;
      d_prod_q   <= d_prod_d;
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== hdl/r1u_checker.sv =====
module r1u_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input r1u_pkg::out_word_t out_data_o
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // input side is ready exactly when the output register can move
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  // a saturated result sits at one of the range limits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status == r1u_pkg::ST_SAT) |->
      (out_data_o.updated_value == r1u_pkg::SAT_HI) ||
      (out_data_o.updated_value == r1u_pkg::SAT_LO))
    else $error("saturated status without a saturated value");

endmodule

bind rank_one_matrix_update_top r1u_checker u_r1u_checker (.*);

// ===== sim/rank_one_matrix_update_top_test.sv =====
module rank_one_matrix_update_top_test;
  import r1u_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int PIPE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT = 300000;

  // Tracks alpha, the index limits and both vector stores; holds the
  // updated elements still owed by the block.
  class ger_shadow;
    logic signed [DATA_W-1:0] x_vals [MAX_ROWS];
    logic signed [DATA_W-1:0] ys_vals [MAX_COLS];
    logic signed [DATA_W-1:0] alpha;
    logic [CNT_W-1:0] row_lim;
    logic [CNT_W-1:0] col_lim;
    out_word_t due_q [$];
    int bad;

    function new();
      alpha = ALPHA_RESET;
      row_lim = ROWS_RESET;
      col_lim = COLS_RESET;
      bad = 0;
    endfunction

    function logic [DATA_W-1:0] clip(input longint v, output bit hit);
      hit = (v > Q_MAX) || (v < Q_MIN);
      if (v > Q_MAX) return Q_MAX[DATA_W-1:0];
      if (v < Q_MIN) return Q_MIN[DATA_W-1:0];
      return v[DATA_W-1:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
      case (idx)
        CFG_ALPHA: alpha = d;
        CFG_ROWS:  row_lim = d[CNT_W-1:0];
        CFG_COLS:  col_lim = d[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_word(in_word_t w);
      longint prod;
      bit hit;
      out_word_t e;
      case (w.operation)
        OP_LOAD_X: x_vals[w.row_index] = w.data_value;
        OP_LOAD_Y: begin
          // alpha * y lands in the store saturated, with no flag
          prod = (longint'($signed(alpha)) * longint'($signed(w.data_value))) >>> FRAC_BITS;
          ys_vals[w.col_index] = clip(prod, hit);
        end
        OP_UPDATE: begin
          e.out_row = w.row_index;
          e.out_col = w.col_index;
          if (w.row_index >= row_lim || w.col_index >= col_lim) begin
            e.updated_value = w.data_value;
            e.status = ST_RANGE;
          end else begin
            prod = (longint'($signed(x_vals[w.row_index])) *
                    longint'($signed(ys_vals[w.col_index]))) >>> FRAC_BITS;
            e.updated_value = clip(longint'($signed(w.data_value)) + prod, hit);
            e.status = hit ? ST_SAT : ST_OK;
          end
          due_q.push_back(e);
        end
        default: ;
      endcase
    endfunction

    function void match_element(out_word_t got);
      out_word_t e;
      if (due_q.size() == 0) begin
        bad++;
        if (bad <= 10)
          $display("unexpected word: value %h row %0d col %0d status %0d",
                   got.updated_value, got.out_row, got.out_col, got.status);
        return;
      end
      e = due_q.pop_front();
      if (got.updated_value !== e.updated_value || got.out_row !== e.out_row ||
          got.out_col !== e.out_col || got.status !== e.status) begin
        bad++;
        if (bad <= 10)
          $display("mismatch: expected value %h row %0d col %0d status %0d, got %h %0d %0d %0d",
                   e.updated_value, e.out_row, e.out_col, e.status,
                   got.updated_value, got.out_row, got.out_col, got.status);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_ready_o;
  in_word_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_word_t out_data_o;

  ger_shadow shadow = new();
  bit x_known [MAX_ROWS];
  bit y_known [MAX_COLS];
  int in_calm = 0;
  int out_calm = 0;
  int unsigned cycles = 0;

  rank_one_matrix_update_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("rank_one_matrix_update_top_test: done, errors");
      $finish;
    end
  end

  // Mostly random gaps, with runs of back-to-back words now and then.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 14);
  endfunction

  function automatic logic [DATA_W-1:0] rand_q();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'h0001_0000;
          default: return 32'hFFFF_0000;
        endcase
      end
      1, 2: return $urandom;
      default: return 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(logic [CNT_W-1:0] lim);
    if (lim == 0 || $urandom_range(0, 6) == 0) return 8'($urandom);
    return 8'($urandom_range(0, (lim > 256 ? 256 : lim) - 1));
  endfunction

  function automatic bit in_use(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c);
    return r < shadow.row_lim && c < shadow.col_lim;
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = draw_gap(in_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    shadow.take_word(w);
  endtask

  task automatic issue(logic [1:0] op, logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                       logic [DATA_W-1:0] v);
    in_word_t w;
    w.operation = op;
    w.row_index = r;
    w.col_index = c;
    w.data_value = v;
    if (op == OP_LOAD_X) x_known[r] = 1'b1;
    if (op == OP_LOAD_Y) y_known[c] = 1'b1;
    send_word(w);
  endtask

  // Never read a store entry that has not been loaded: load it instead.
  task automatic rand_update();
    logic [IDX_W-1:0] r;
    logic [IDX_W-1:0] c;
    int n;
    r = pick_index(shadow.row_lim);
    c = pick_index(shadow.col_lim);
    for (n = 0; n < 6 && in_use(r, c) && !(x_known[r] && y_known[c]); n++) begin
      r = pick_index(shadow.row_lim);
      c = pick_index(shadow.col_lim);
    end
    if (in_use(r, c) && !x_known[r])
      issue(OP_LOAD_X, r, 8'($urandom), rand_q());
    else if (in_use(r, c) && !y_known[c])
      issue(OP_LOAD_Y, 8'($urandom), c, rand_q());
    else
      issue(OP_UPDATE, r, c, rand_q());
  endtask

  // Let the pipe empty, loads included, before touching a register.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (shadow.due_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    shadow.set_reg(idx, d);
    @(posedge clk_i);
  endtask

  initial begin
    int gap;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = draw_gap(out_calm);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      shadow.match_element(out_data_o);
    end
  end

  initial begin
    int p;
    int n;
    int k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_ALPHA;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // alpha = 1.0, full size: extremes, exact fits, rounding toward minus infinity
    issue(OP_LOAD_X, 8'd0, 8'd0, 32'h7FFF_FFFF);
    issue(OP_LOAD_X, 8'd255, 8'd0, 32'h8000_0000);
    issue(OP_LOAD_X, 8'd1, 8'd0, 32'h0001_0000);
    issue(OP_LOAD_X, 8'd2, 8'd0, 32'hFFFF_FFFF);
    issue(OP_LOAD_Y, 8'd0, 8'd0, 32'h7FFF_FFFF);
    issue(OP_LOAD_Y, 8'd0, 8'd255, 32'h8000_0000);
    issue(OP_LOAD_Y, 8'd0, 8'd1, 32'hFFFF_0000);
    issue(OP_LOAD_Y, 8'd0, 8'd2, 32'h0000_0001);
    issue(OP_SPARE, 8'd255, 8'd255, 32'hFFFF_FFFF);
    issue(OP_UPDATE, 8'd0, 8'd0, 32'h0000_0000);
    issue(OP_UPDATE, 8'd255, 8'd255, 32'h7FFF_FFFF);
    issue(OP_UPDATE, 8'd0, 8'd255, 32'h8000_0000);
    issue(OP_UPDATE, 8'd1, 8'd1, 32'h0002_0000);
    issue(OP_UPDATE, 8'd1, 8'd0, 32'h0000_0000);
    issue(OP_UPDATE, 8'd255, 8'd1, 32'h8000_0000);
    issue(OP_UPDATE, 8'd2, 8'd2, 32'h0000_0000);

    // most negative alpha, small limits; loads beyond the limits still land
    drain();
    write_reg(CFG_ALPHA, 32'h8000_0000);
    write_reg(CFG_ROWS, 32'd3);
    write_reg(CFG_COLS, 32'd2);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    issue(OP_LOAD_Y, 8'd0, 8'd3, 32'h8000_0000);
    issue(OP_LOAD_Y, 8'd0, 8'd4, 32'h7FFF_FFFF);
    issue(OP_UPDATE, 8'd3, 8'd0, 32'h1234_5678);
    issue(OP_UPDATE, 8'd0, 8'd2, 32'h8765_4321);
    issue(OP_UPDATE, 8'd2, 8'd1, 32'h0003_0000);

    // no rows in use: everything is out of range
    drain();
    write_reg(CFG_ALPHA, 32'h7FFF_FFFF);
    write_reg(CFG_ROWS, 32'd0);
    write_reg(CFG_COLS, 32'd511);
    issue(OP_UPDATE, 8'd0, 8'd0, 32'h0000_1000);

    drain();
    write_reg(CFG_ROWS, 32'd511);
    write_reg(CFG_COLS, 32'd5);
    issue(OP_UPDATE, 8'd1, 8'd3, 32'h0000_0000);
    issue(OP_UPDATE, 8'd255, 8'd4, 32'h0000_0000);
    issue(OP_LOAD_Y, 8'd0, 8'd5, 32'h0001_0000);
    issue(OP_UPDATE, 8'd0, 8'd5, 32'h0000_0000);

    for (p = 0; p < 8; p++) begin
      drain();
      case ($urandom_range(0, 5))
        0: write_reg(CFG_ALPHA, ALPHA_RESET);
        1: write_reg(CFG_ALPHA, 32'h7FFF_FFFF);
        2: write_reg(CFG_ALPHA, 32'h8000_0000);
        5: write_reg(CFG_ALPHA, $urandom);
        default: write_reg(CFG_ALPHA, 32'($urandom_range(0, 32'h7FFFF)) - 32'h40000);
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_ROWS, 32'd256);
        1: write_reg(CFG_ROWS, 32'd1);
        2: write_reg(CFG_ROWS, 32'($urandom_range(257, 511)));
        default: write_reg(CFG_ROWS, 32'($urandom_range(1, 24)));
      endcase
      case ($urandom_range(0, 7))
        0: write_reg(CFG_COLS, 32'd256);
        1: write_reg(CFG_COLS, 32'd1);
        2: write_reg(CFG_COLS, 32'd0);
        default: write_reg(CFG_COLS, 32'($urandom_range(1, 24)));
      endcase
      n = 0;
      while (n < 50) begin
        k = $urandom_range(0, 99);
        if (k < 5) begin
          issue(OP_SPARE, 8'($urandom), 8'($urandom), $urandom);
        end else begin
          if (k < 25)
            issue(OP_LOAD_X, pick_index(shadow.row_lim), 8'($urandom), rand_q());
          else if (k < 45)
            issue(OP_LOAD_Y, 8'($urandom), pick_index(shadow.col_lim), rand_q());
          else
            rand_update();
          n++;
        end
      end
    end

    drain();
    if (shadow.bad == 0 && shadow.due_q.size() == 0)
      $display("rank_one_matrix_update_top_test: done, clean");
    else
      $display("rank_one_matrix_update_top_test: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/r1u_pkg.sv
hdl/r1u_ram.sv
hdl/rank_one_matrix_update_top.sv
hdl/r1u_checker.sv
sim/rank_one_matrix_update_top_test.sv
